// ----- rtl/core/gnlf_pkg.sv -----
package gnlf_pkg;

   localparam int DataWidth    = 32;
   localparam int SumWidth     = 50;
   localparam int ProdWidth    = 64;
   localparam int PosWidth     = 48;
   localparam int DivNumWidth  = 64;
   localparam int DivQuotWidth = 41;
   localparam int DivCntWidth  = 7;

   // 360 * 2^32 is a 41-bit value; it enters the divider left-aligned
   localparam logic [DivNumWidth-1:0] WrapNum   = 64'd360 << 55;
   localparam logic [DivCntWidth-1:0] WrapSteps = 7'd41;
   localparam logic [DivCntWidth-1:0] TickSteps = 7'd32;

   localparam logic [2:0] MODE_WRAP_ADD   = 3'd0;
   localparam logic [2:0] MODE_ADD_CLAMP  = 3'd1;
   localparam logic [2:0] MODE_SUB_CLAMP  = 3'd2;
   localparam logic [2:0] MODE_SET_TARGET = 3'd3;
   localparam logic [2:0] MODE_SET_BOTH   = 3'd4;
   localparam logic [2:0] MODE_TICK       = 3'd5;

   localparam logic [1:0] REG_SCALE    = 2'd0;
   localparam logic [1:0] REG_OFFSET   = 2'd1;
   localparam logic [1:0] REG_FRICTION = 2'd2;

   typedef struct packed {
      logic signed [DataWidth-1:0] scale;
      logic signed [DataWidth-1:0] offset;
      logic [DataWidth-2:0]        friction;
   } cfg_type;

   typedef struct packed {
      logic                   start;
      logic [DataWidth-1:0]   rem;
      logic [DivNumWidth-1:0] num;
      logic [DataWidth-1:0]   den;
      logic [DivCntWidth-1:0] steps;
   } div_req_type;

   function automatic logic signed [DataWidth-1:0] sat32(input logic signed [SumWidth-1:0] v);
      logic signed [DataWidth-1:0] r;
      if (v > 50'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -50'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[DataWidth-1:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/gnlf_div.sv -----
module gnlf_div
   import gnlf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  div_req_type             req,
   output logic                    busy,
   output logic [DivQuotWidth-1:0] quot
);

   logic [DivCntWidth-1:0]  count_ff, count_in;
   logic [DataWidth-1:0]    rem_ff, rem_in;
   logic [DivNumWidth-1:0]  num_ff, num_in;
   logic [DataWidth-1:0]    den_ff, den_in;
   logic [DivQuotWidth-1:0] quot_ff, quot_in;
   logic [DataWidth:0]      trial;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial    = {rem_ff, num_ff[DivNumWidth-1]} - {1'b0, den_ff};
      count_in = count_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      if (req.start) begin
         count_in = req.steps;
         rem_in   = req.rem;
         num_in   = req.num;
         den_in   = req.den;
         quot_in  = '0;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         num_in   = {num_ff[DivNumWidth-2:0], 1'b0};
         if (!trial[DataWidth]) begin
            rem_in  = trial[DataWidth-1:0];
            quot_in = {quot_ff[DivQuotWidth-2:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[DataWidth-2:0], num_ff[DivNumWidth-1]};
            quot_in = {quot_ff[DivQuotWidth-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign busy = (count_ff != '0);
   assign quot = quot_ff;

endmodule

// ----- rtl/core/gnlf_csr.sv -----
module gnlf_csr
   import gnlf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [DataWidth-1:0] pwdata,
   output logic [DataWidth-1:0] prdata,
   output logic                 pready,
   output cfg_type              cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[3:2])
            REG_SCALE:    cfg_in.scale    = pwdata;
            REG_OFFSET:   cfg_in.offset   = pwdata;
            REG_FRICTION: cfg_in.friction = pwdata[DataWidth-2:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_SCALE:    prdata = cfg_ff.scale;
         REG_OFFSET:   prdata = cfg_ff.offset;
         REG_FRICTION: prdata = {1'b0, cfg_ff.friction};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale    <= 32'sh00010000;
         cfg_ff.offset   <= '0;
         cfg_ff.friction <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/gauge_needle_lag_filter_core.sv -----
// Needle damper: one transaction in, one result out, one item in flight.
// The transaction passes through the MUL, SCALE, SUM and FIN states, and through DIV for a damped
// tick (32-step division) or a wrapping add with nonzero scale (41-step division).
// Input is ready again in the cycle the result turns valid, so a new transaction is
// accepted only after the last one is done. Synchronous active-high reset clears
// needle and target to zero, scale to 1.0, offset and friction to zero.
module gauge_needle_lag_filter_core
   import gnlf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // amount[31:0], elapsed[62:32], zero[63]
   input  logic [2:0]  req_tuser,   // mode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // needle_position[31:0], target_position[63:32]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_SCALE = 6'b000100,
      ST_SUM   = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   cfg_type                     cfg;
   div_req_type                 div_req;
   logic                        div_busy;
   logic [DivQuotWidth-1:0]     div_quot;

   state_type                   state_ff, state_in;
   logic [2:0]                  mode_ff, mode_in;
   logic signed [DataWidth-1:0] amount_ff, amount_in;
   logic [DataWidth-2:0]        elapsed_ff, elapsed_in;
   logic signed [DataWidth-1:0] needle_ff, needle_in;
   logic signed [DataWidth-1:0] target_ff, target_in;
   logic signed [ProdWidth-1:0] prod_ff, prod_in;
   logic                        snap_ff, snap_in;
   logic signed [PosWidth-1:0]  p_ff, p_in;
   logic [ProdWidth-1:0]        mag_ff, mag_in;
   logic                        neg_ff, neg_in;
   logic signed [SumWidth-1:0]  t_ff, t_in;
   logic signed [SumWidth-1:0]  tw_ff, tw_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [63:0]                 rsp_data_ff, rsp_data_in;

   logic signed [DataWidth:0]   op_a, op_b;
   logic signed [65:0]          mult;
   logic signed [ProdWidth-1:0] prod_adj;
   logic signed [SumWidth-1:0]  target_x, p_x, off_x, base, psum;
   logic signed [SumWidth-1:0]  needle_x, quot_x, w_val, delta, lim;
   logic [DataWidth-1:0]        scale_mag;
   logic                        div_go, commit;
   logic signed [DataWidth-1:0] new_needle, new_target;

   gnlf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   gnlf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // shared multiplier: amount*scale, or elapsed*(target-needle) on tick
   always_comb begin
      if (mode_ff == MODE_TICK) begin
         op_a = {2'b00, elapsed_ff};
         op_b = {target_ff[DataWidth-1], target_ff} - {needle_ff[DataWidth-1], needle_ff};
      end else begin
         op_a = {amount_ff[DataWidth-1], amount_ff};
         op_b = {cfg.scale[DataWidth-1], cfg.scale};
      end
   end
   assign mult = op_a * op_b;

   // divide by 2^16 toward zero
   assign prod_adj = prod_ff + {48'd0, {16{prod_ff[ProdWidth-1]}}};

   assign target_x  = {{(SumWidth-DataWidth){target_ff[DataWidth-1]}}, target_ff};
   assign needle_x  = {{(SumWidth-DataWidth){needle_ff[DataWidth-1]}}, needle_ff};
   assign p_x       = {{(SumWidth-PosWidth){p_ff[PosWidth-1]}}, p_ff};
   assign off_x     = {{(SumWidth-DataWidth){cfg.offset[DataWidth-1]}}, cfg.offset};
   assign scale_mag = cfg.scale[DataWidth-1] ? (32'd0 - cfg.scale) : cfg.scale;
   assign quot_x    = {{(SumWidth-DivQuotWidth){1'b0}}, div_quot};
   assign w_val     = cfg.scale[DataWidth-1] ? -quot_x : quot_x;
   assign delta     = neg_ff ? -quot_x : quot_x;
   assign lim       = {{(SumWidth-DataWidth){cfg.scale[DataWidth-1]}}, cfg.scale} + off_x;

   assign div_go = ((mode_ff == MODE_WRAP_ADD) && (cfg.scale != '0)) ||
                   ((mode_ff == MODE_TICK) && !snap_ff);
   assign commit = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      base = ((mode_ff == MODE_SET_TARGET) || (mode_ff == MODE_SET_BOTH)) ? '0 : target_x;
      psum = (mode_ff == MODE_SUB_CLAMP) ? (base - p_x) : (base + p_x);
   end

   always_comb begin
      div_req.start = (state_ff == ST_SUM) && div_go;
      if (mode_ff == MODE_TICK) begin
         div_req.rem   = mag_ff[ProdWidth-1:DataWidth];
         div_req.num   = {mag_ff[DataWidth-1:0], 32'd0};
         div_req.den   = {1'b0, cfg.friction};
         div_req.steps = TickSteps;
      end else begin
         div_req.rem   = '0;
         div_req.num   = WrapNum;
         div_req.den   = scale_mag;
         div_req.steps = WrapSteps;
      end
   end

   // final state update
   always_comb begin
      new_needle = needle_ff;
      new_target = target_ff;
      case (mode_ff)
         MODE_WRAP_ADD: begin
            if ((cfg.scale != '0) && (tw_ff > w_val)) begin
               new_target = sat32(t_ff - w_val);
               new_needle = sat32(needle_x - w_val);
            end else begin
               new_target = sat32(t_ff);
            end
         end
         MODE_ADD_CLAMP: begin
            new_target = sat32((t_ff > lim) ? lim : t_ff);
         end
         MODE_SUB_CLAMP: begin
            new_target = sat32((t_ff < 0) ? '0 : t_ff);
         end
         MODE_SET_TARGET: begin
            new_target = sat32(t_ff);
         end
         MODE_SET_BOTH: begin
            new_target = sat32(t_ff);
            new_needle = sat32(t_ff);
         end
         MODE_TICK: begin
            new_needle = snap_ff ? target_ff : sat32(needle_x + delta);
         end
         default: begin
            new_needle = needle_ff;
            new_target = target_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      amount_in    = amount_ff;
      elapsed_in   = elapsed_ff;
      needle_in    = needle_ff;
      target_in    = target_ff;
      prod_in      = prod_ff;
      snap_in      = snap_ff;
      p_in         = p_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      t_in         = t_ff;
      tw_in        = tw_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // drop the result once taken; a commit in the same cycle overrides
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in    = req_tuser;
               amount_in  = req_tdata[31:0];
               elapsed_in = req_tdata[62:32];
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = mult[ProdWidth-1:0];
            snap_in  = (cfg.friction == '0) ||
                       ({elapsed_ff, 1'b0} >= {1'b0, cfg.friction});
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            p_in     = prod_adj[ProdWidth-1:16];
            neg_in   = prod_ff[ProdWidth-1];
            mag_in   = prod_ff[ProdWidth-1] ? (64'd0 - prod_ff) : prod_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            tw_in    = psum;
            t_in     = psum + off_x;
            state_in = div_go ? ST_DIV : ST_FIN;
         end
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // hold until the output register is free
            if (commit) begin
               needle_in    = new_needle;
               target_in    = new_target;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {new_target, new_needle};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         needle_ff    <= '0;
         target_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         needle_ff    <= needle_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      amount_ff   <= amount_in;
      elapsed_ff  <= elapsed_in;
      prod_ff     <= prod_in;
      snap_ff     <= snap_in;
      p_ff        <= p_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      t_ff        <= t_in;
      tw_ff       <= tw_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- bench/gauge_needle_lag_filter_core_tb.sv -----
module gauge_needle_lag_filter_core_tb;
   import gnlf_pkg::*;

   localparam logic [2:0] MODE_SPARE_6 = 3'd6;
   localparam logic [2:0] MODE_SPARE_7 = 3'd7;
   localparam logic signed [31:0] Q16_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] Q16_MIN = 32'sh80000000;
   localparam int unsigned RANDOM_PHASES = 12;
   localparam int unsigned PHASE_ITEMS = 120;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] amount;
      logic [30:0] elapsed;
   } gauge_cmd_type;

   typedef struct packed {
      logic [31:0] needle;
      logic [31:0] target;
   } gauge_pos_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // amount[31:0], elapsed[62:32], zero[63]
   logic [2:0]  req_tuser = '0;   // mode[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // needle_position[31:0], target_position[63:32]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predicted registers and positions
   logic signed [31:0] cfg_scale = 32'sh00010000;
   logic signed [31:0] cfg_offset = '0;
   logic [30:0]        cfg_friction = '0;
   logic signed [31:0] needle_now = '0;
   logic signed [31:0] target_now = '0;

   gauge_cmd_type  pending_cmds[$];
   gauge_pos_type  expected_pos[$];
   bit          req_fire = 1'b0;
   bit          idling_on = 1'b0;
   int unsigned send_hold = 0;
   int unsigned recv_hold = 0;
   int unsigned fail_count = 0;

   gauge_needle_lag_filter_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic logic signed [31:0] clamp_q16(input longint v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = Q16_MAX;
      end else if (v < -64'sd2147483648) begin
         r = Q16_MIN;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

   // Update the predicted positions for one transaction and return what the block reports.
   function automatic gauge_pos_type advance_gauge(input gauge_cmd_type cmd);
      longint     sc;
      longint     of;
      longint     el;
      longint     scaled;
      longint     sum;
      longint     span;
      longint     gap;
      longint     delta;
      gauge_pos_type res;
      sc = longint'(cfg_scale);
      of = longint'(cfg_offset);
      el = longint'(cmd.elapsed);
      scaled = (longint'($signed(cmd.amount)) * sc) / 64'sd65536;
      case (cmd.mode)
         MODE_WRAP_ADD: begin
            sum = longint'(target_now) + scaled + of;
            // zero gain leaves the span undefined: skip the wrap
            if (sc != 0) begin
               span = (longint'(360) <<< 32) / sc;
               if (sum - of > span) begin
                  sum -= span;
                  needle_now = clamp_q16(longint'(needle_now) - span);
               end
            end
            target_now = clamp_q16(sum);
         end
         MODE_ADD_CLAMP: begin
            sum = longint'(target_now) + scaled + of;
            if (sum > sc + of) sum = sc + of;
            target_now = clamp_q16(sum);
         end
         MODE_SUB_CLAMP: begin
            sum = longint'(target_now) - scaled + of;
            if (sum < 0) sum = 0;
            target_now = clamp_q16(sum);
         end
         MODE_SET_TARGET: begin
            target_now = clamp_q16(scaled + of);
         end
         MODE_SET_BOTH: begin
            target_now = clamp_q16(scaled + of);
            needle_now = target_now;
         end
         MODE_TICK: begin
            if (cfg_friction != 0 && 2 * el < longint'(cfg_friction)) begin
               gap = longint'(target_now) - longint'(needle_now);
               delta = (el * gap) / longint'(cfg_friction);
               needle_now = clamp_q16(longint'(needle_now) + delta);
            end else begin
               needle_now = target_now;
            end
         end
         default: ;
      endcase
      res.needle = needle_now;
      res.target = target_now;
      return res;
   endfunction

   function automatic logic [31:0] signed_small(input int unsigned bound);
      logic [31:0] v;
      v = $urandom_range(0, bound);
      if ($urandom_range(0, 1) != 0) v = -v;
      return v;
   endfunction

   function automatic logic [31:0] pick_q16(input int unsigned spread);
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = Q16_MAX;
         2: v = Q16_MIN;
         3: v = $urandom;
         default: v = signed_small(spread);
      endcase
      return v;
   endfunction

   function automatic logic [30:0] pick_friction();
      logic [30:0] v;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = 31'h7FFFFFFF;
         2: v = 31'd1;
         3: v = 31'($urandom);
         default: v = 31'($urandom_range(2, 32'h80000));
      endcase
      return v;
   endfunction

   function automatic gauge_cmd_type random_cmd();
      gauge_cmd_type  c;
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 3) c.mode = MODE_WRAP_ADD;
      else if (pick < 5) c.mode = MODE_ADD_CLAMP;
      else if (pick < 7) c.mode = MODE_SUB_CLAMP;
      else if (pick < 9) c.mode = MODE_SET_TARGET;
      else if (pick < 10) c.mode = MODE_SET_BOTH;
      else if (pick < 19) c.mode = MODE_TICK;
      else c.mode = ($urandom_range(0, 1) != 0) ? MODE_SPARE_6 : MODE_SPARE_7;
      c.amount = pick_q16(32'hA0000);
      pick = $urandom_range(0, 9);
      // keep most ticks inside the damped range so the needle actually lags
      if (cfg_friction >= 4 && pick < 7) begin
         c.elapsed = 31'($urandom_range(0, cfg_friction / 2 - 1));
      end else if (cfg_friction >= 4 && pick < 8) begin
         c.elapsed = 31'($urandom_range(cfg_friction / 2, cfg_friction));
      end else begin
         c.elapsed = 31'($urandom);
      end
      return c;
   endfunction

   task automatic queue_cmd(input logic [2:0] mode, input logic [31:0] amount,
                            input logic [30:0] elapsed);
      gauge_cmd_type c;
      c.mode = mode;
      c.amount = amount;
      c.elapsed = elapsed;
      pending_cmds.push_back(c);
   endtask

   // Wait until every queued transaction has been answered.
   task automatic drain();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_tvalid || expected_pos.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] stored;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      stored = value;
      case (idx)
         REG_SCALE: cfg_scale = value;
         REG_OFFSET: cfg_offset = value;
         REG_FRICTION: begin
            cfg_friction = value[30:0];
            stored = {1'b0, value[30:0]};
         end
         default: ;
      endcase
      // read back the same register
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== stored) begin
         $error("csr register %0d: expected %h, actual %h", idx, stored, csr_prdata);
         fail_count++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic load_config(input logic [31:0] scale, input logic [31:0] offset,
                              input logic [30:0] friction);
      write_csr(REG_SCALE, scale);
      write_csr(REG_OFFSET, offset);
      write_csr(REG_FRICTION, {1'b0, friction});
   endtask

   // sender
   always @(negedge clock) begin
      gauge_cmd_type c;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (send_hold > 0) begin
            send_hold--;
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            c = pending_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= c.mode;
            req_tdata <= {1'b0, c.elapsed, c.amount};
            if (idling_on && $urandom_range(0, 3) == 0) send_hold = $urandom_range(1, 19);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      if (recv_hold > 0) begin
         recv_hold--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
         recv_hold = $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      gauge_cmd_type c;
      gauge_pos_type want;
      req_fire = !reset && req_tvalid && req_tready;
      if (req_fire) begin
         c.mode = req_tuser;
         c.amount = req_tdata[31:0];
         c.elapsed = req_tdata[62:32];
         expected_pos.push_back(advance_gauge(c));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pos.size() == 0) begin
            $error("unexpected result transaction: needle_position %h target_position %h",
                   rsp_tdata[31:0], rsp_tdata[63:32]);
            fail_count++;
         end else begin
            want = expected_pos.pop_front();
            if (rsp_tdata[31:0] !== want.needle) begin
               $error("needle_position: expected %0d, actual %0d",
                      $signed(want.needle), $signed(rsp_tdata[31:0]));
               fail_count++;
            end
            if (rsp_tdata[63:32] !== want.target) begin
               $error("target_position: expected %0d, actual %0d",
                      $signed(want.target), $signed(rsp_tdata[63:32]));
               fail_count++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers at their reset values: unit gain, no offset, no damping
      queue_cmd(MODE_SET_BOTH, Q16_MAX, 31'h7FFFFFFF);
      queue_cmd(MODE_WRAP_ADD, Q16_MAX, '0);
      queue_cmd(MODE_ADD_CLAMP, Q16_MIN, '0);
      queue_cmd(MODE_SUB_CLAMP, Q16_MAX, '0);
      queue_cmd(MODE_SET_TARGET, Q16_MIN, '0);
      queue_cmd(MODE_TICK, 32'hFFFFFFFF, '0);
      queue_cmd(MODE_SPARE_6, 32'hFFFFFFFF, 31'h7FFFFFFF);
      queue_cmd(MODE_SPARE_7, '0, '0);
      drain();

      // most negative gain, largest offset and friction
      load_config(Q16_MIN, Q16_MAX, 31'h7FFFFFFF);
      queue_cmd(MODE_WRAP_ADD, 32'h00010000, '0);
      queue_cmd(MODE_SET_BOTH, Q16_MIN, '0);
      queue_cmd(MODE_SET_TARGET, 32'h00000001, '0);
      queue_cmd(MODE_TICK, '0, 31'h3FFFFFFF);
      queue_cmd(MODE_TICK, '0, 31'h40000000);
      queue_cmd(MODE_TICK, '0, 31'h7FFFFFFF);
      drain();

      // zero gain: wrap add must not wrap
      load_config('0, Q16_MIN, 31'd1);
      queue_cmd(MODE_WRAP_ADD, Q16_MAX, '0);
      queue_cmd(MODE_ADD_CLAMP, Q16_MIN, '0);
      queue_cmd(MODE_SUB_CLAMP, Q16_MAX, '0);
      queue_cmd(MODE_TICK, Q16_MAX, '0);
      drain();

      load_config(Q16_MAX, '0, 31'h10000);
      queue_cmd(MODE_SET_BOTH, 32'h00010000, '0);
      queue_cmd(MODE_SET_TARGET, -32'sd65536, '0);
      queue_cmd(MODE_TICK, '0, 31'h4000);
      queue_cmd(MODE_TICK, '0, 31'h4000);
      queue_cmd(MODE_WRAP_ADD, 32'h00020000, '0);
      drain();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         // no idling in the final phase
         idling_on = (ph < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         load_config(pick_q16(32'h40000), pick_q16(32'h80000), pick_friction());
         repeat (PHASE_ITEMS) pending_cmds.push_back(random_cmd());
         drain();
      end

      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
